/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dtp_pkg.sv */
`default_nettype none

package dtp_pkg;

  localparam logic [29:0] NsPerSec    = 30'd1000000000;
  localparam logic [34:0] SecLimit    = 35'd18446744073;
  localparam logic [19:0] NsPerMilli  = 20'd1000000;
  localparam logic [9:0]  ScaleStep   = 10'd1000;
  localparam logic [3:0]  FracMaxDig  = 4'd9;
  localparam logic [3:0]  FracCntMax  = 4'd15;
  localparam logic [7:0]  CharDot     = 8'h2E;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadFrac  = 2'd1,
    StOverflow = 2'd2
  } status_e;

  // Parse state captured at the byte that ends the timestamp.
  typedef struct packed {
    logic [34:0] sec;
    logic [29:0] frac;
    logic [3:0]  cnt;
    logic        ovf;
    logic [7:0]  endc;
  } fin_t;

  // Partial products and decoded status.
  typedef struct packed {
    logic [47:0] prod_lo;
    logic [46:0] prod_hi;
    logic [29:0] frac_ns;
    status_e     st;
    logic [7:0]  endc;
  } prod_t;

  // Whole-second nanoseconds, ready for the fraction add.
  typedef struct packed {
    logic [63:0] base;
    logic [29:0] frac_ns;
    status_e     st;
    logic [7:0]  endc;
  } base_t;

endpackage

`default_nettype wire

/* design/decimal_timestamp_parser.sv */
`default_nettype none

// Decimal timestamp parser. Takes one byte per cycle; line_start_i marks the
// first byte of a line. Parses decimal seconds, an optional '.' and 0/3/6/9
// fraction digits, and at the first byte that ends the timestamp delivers one
// transaction: time_ns_o (zero unless status is ok), status_o (0 ok, 1 bad
// fraction digit count, 2 overflow) and end_char_o. The byte parser updates
// its accumulators in the accepting cycle, so bytes stream at one per cycle
// with no gaps while in_ready_o is high. The nanosecond conversion runs in a
// four-register pipeline (capture, split 35x30 multiply, partial product add,
// fraction add with carry check). Input stalls only when every pipeline
// register is full and out_ready_i is low.
module decimal_timestamp_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        line_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      time_ns_o,
  output logic [1:0]       status_o,
  output logic [7:0]       end_char_o
);
  import dtp_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhSec  = 2'd1,
    PhFrac = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d, eff_phase;
  logic [34:0] sec_q, sec_d, eff_sec;
  logic [29:0] frac_q, frac_d, eff_frac;
  logic [3:0]  cnt_q, cnt_d, eff_cnt;
  logic        ovf_q, ovf_d, eff_ovf;
  logic        is_digit;
  logic [38:0] sec_mac;
  logic [33:0] frac_mac;
  logic        in_fire, fin_fire;

  fin_t        s1_q, s1_d;
  prod_t       s2_q, s2_d;
  base_t       s3_q, s3_d;
  logic [63:0] ns_q, ns_d;
  status_e     st_q, st_d;
  logic [7:0]  endc_q;
  logic [64:0] sum;
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        rdy1, rdy2, rdy3, rdy4;

  // Per-stage ready lets bubbles collapse behind a stalled output.
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && in_ready_o;

  // Byte parser
  always_comb begin
    eff_phase = line_start_i ? PhSec : phase_q;
    eff_sec   = line_start_i ? '0 : sec_q;
    eff_frac  = line_start_i ? '0 : frac_q;
    eff_cnt   = line_start_i ? '0 : cnt_q;
    eff_ovf   = line_start_i ? 1'b0 : ovf_q;
    is_digit  = byte_in_i inside {[8'h30:8'h39]};
    sec_mac   = {1'b0, eff_sec, 3'b000} + {3'b000, eff_sec, 1'b0}
              + {35'd0, byte_in_i[3:0]};
    frac_mac  = {1'b0, eff_frac, 3'b000} + {3'b000, eff_frac, 1'b0}
              + {30'd0, byte_in_i[3:0]};

    phase_d  = phase_q;
    sec_d    = sec_q;
    frac_d   = frac_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    fin_fire = 1'b0;

    if (in_fire) begin
      phase_d = eff_phase;
      sec_d   = eff_sec;
      frac_d  = eff_frac;
      cnt_d   = eff_cnt;
      ovf_d   = eff_ovf;
      case (eff_phase)
        PhSec: begin
          if (is_digit) begin
            if (!eff_ovf) begin
              if (sec_mac > {4'd0, SecLimit}) begin
                ovf_d = 1'b1;
              end else begin
                sec_d = sec_mac[34:0];
              end
            end
          end else if (byte_in_i == CharDot) begin
            phase_d = PhFrac;
          end else begin
            fin_fire = 1'b1;
            phase_d  = PhIdle;
          end
        end
        PhFrac: begin
          if (is_digit) begin
            if (eff_cnt < FracMaxDig) begin
              frac_d = frac_mac[29:0];
            end
            if (eff_cnt < FracCntMax) begin
              cnt_d = eff_cnt + 4'd1;
            end
          end else begin
            fin_fire = 1'b1;
            phase_d  = PhIdle;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  assign s1_d = '{sec: eff_sec, frac: eff_frac, cnt: eff_cnt, ovf: eff_ovf,
                  endc: byte_in_i};

  // Split multiply and fraction scaling
  always_comb begin
    s2_d.prod_lo = 48'(s1_q.sec[17:0]) * 48'(NsPerSec);
    s2_d.prod_hi = 47'(s1_q.sec[34:18]) * 47'(NsPerSec);
    s2_d.endc    = s1_q.endc;
    case (s1_q.cnt)
      4'd3: begin
        s2_d.frac_ns = 30'(s1_q.frac[9:0]) * 30'(NsPerMilli);
        s2_d.st      = s1_q.ovf ? StOverflow : StOk;
      end
      4'd6: begin
        s2_d.frac_ns = 30'(s1_q.frac[19:0]) * 30'(ScaleStep);
        s2_d.st      = s1_q.ovf ? StOverflow : StOk;
      end
      4'd9: begin
        s2_d.frac_ns = s1_q.frac;
        s2_d.st      = s1_q.ovf ? StOverflow : StOk;
      end
      4'd0: begin
        s2_d.frac_ns = '0;
        s2_d.st      = s1_q.ovf ? StOverflow : StOk;
      end
      default: begin
        s2_d.frac_ns = '0;
        s2_d.st      = StBadFrac;
      end
    endcase
  end

  // Seconds never exceed the limit, so the whole-second product fits 64 bits.
  always_comb begin
    s3_d.base    = {16'd0, s2_q.prod_lo} + {s2_q.prod_hi[45:0], 18'd0};
    s3_d.frac_ns = s2_q.frac_ns;
    s3_d.st      = s2_q.st;
    s3_d.endc    = s2_q.endc;
  end

  // Fraction add; a carry out means the total passed 2^64-1.
  always_comb begin
    sum  = {1'b0, s3_q.base} + {35'd0, s3_q.frac_ns};
    st_d = s3_q.st;
    ns_d = sum[63:0];
    if (s3_q.st == StOk && sum[64]) begin
      st_d = StOverflow;
    end
    if (st_d != StOk) begin
      ns_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      sec_q   <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sec_q   <= sec_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      if (rdy1) v1_q <= fin_fire;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && fin_fire) s1_q <= s1_d;
    if (rdy2 && v1_q) s2_q <= s2_d;
    if (rdy3 && v2_q) s3_q <= s3_d;
    if (rdy4 && v3_q) begin
      ns_q   <= ns_d;
      st_q   <= st_d;
      endc_q <= s3_q.endc;
    end
  end

  assign out_valid_o = v4_q;
  assign time_ns_o   = ns_q;
  assign status_o    = st_q;
  assign end_char_o  = endc_q;

  `ASSERT_ALWAYS(a_sec_in_range, clk_i, rst_ni, sec_q <= SecLimit, "seconds above limit")
  `ASSERT_IMPLIES(a_sec_no_frac, clk_i, rst_ni, phase_q == PhSec, cnt_q == 4'd0 && frac_q == '0, "fraction state set during seconds")
  `ASSERT_IMPLIES(a_err_zero_ns, clk_i, rst_ni, out_valid_o && status_o != StOk, time_ns_o == '0, "nonzero time on error")
  `ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, v1_q && !rdy2, v1_q && $stable(s1_q), "capture stage lost while stalled")

endmodule

`default_nettype wire
